FILE: rtl/core/lfrd_pkg.sv
// Package for the lagged Fibonacci random draw block.
// Holds default parameters, action codes, sequencer states and fixed constants.
// No dependencies.
package lfrd_pkg;

    // Default ring geometry
    localparam int DEF_TABLE_LEN = 55;
    localparam int DEF_LAG       = 24;
    localparam int DEF_HALF_BITS = 15;

    // Bound used by coin flip and percent chance, and the coin threshold
    localparam logic [31:0] CHANCE_BOUND = 32'd100;
    localparam logic [31:0] COIN_LIMIT   = 32'd50;

    // Seed loaded by the post-reset fill
    localparam logic [29:0] RESET_SEED = 30'd1;

    typedef enum logic [1:0] {
        ACT_DRAW   = 2'd0,
        ACT_COIN   = 2'd1,
        ACT_CHANCE = 2'd2,
        ACT_RESEED = 2'd3
    } lfrd_action_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_MUL,
        ST_OUT
    } lfrd_state_t;

endpackage

FILE: rtl/core/lagged_fibonacci_random_draw_top.sv
// Lagged Fibonacci random draw block: ring memory, sequencer and shared multiplier.
// Depends on lfrd_pkg.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_action s_operand      | in
//          | s_seed_value                            |
//  result  | m_valid m_ready m_value                 | out
//
// A draw, coin flip or chance word passes from acceptance to a loaded result
// through accept, ring read, add and write-back, multiply and result states;
// the ring memory ports and the single multiplier set these steps.
// A reseed refills the ring from the seed value, one ring entry per cycle.
// After reset the ring is filled from seed one; s_ready stays low during that
// pass. A stalled result holds in the output register while the next word is
// accepted; the sequencer waits only to load a new one.
module lagged_fibonacci_random_draw_top
    import lfrd_pkg::*;
#(
    parameter int TABLE_LEN = DEF_TABLE_LEN,
    parameter int LAG       = DEF_LAG,
    parameter int HALF_BITS = DEF_HALF_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_operand,
    input  logic [29:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value
);

    localparam int WORD_BITS = 2 * HALF_BITS;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int BACK      = (LAG + 1) % TABLE_LEN;
    localparam int PROD_W    = HALF_BITS + 32;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_LEN - 1);
    localparam logic [IDX_W:0]   BACK_X   = (IDX_W + 1)'(BACK);
    localparam logic [IDX_W:0]   FWD_X    = (IDX_W + 1)'(TABLE_LEN - BACK);

    // Ring storage
    logic [WORD_BITS-1:0] ring_mem [TABLE_LEN];

    // Sequencer and datapath registers
    lfrd_state_t          state_reg, state_next;
    lfrd_action_t         action_reg, action_next;
    logic [31:0]          bound_reg, bound_next;
    logic [31:0]          percent_reg, percent_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     fill_idx_reg, fill_idx_next;
    logic [WORD_BITS-1:0] fill_word_reg, fill_word_next;
    logic                 fill_out_reg, fill_out_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [WORD_BITS-1:0] near_rd_reg, far_rd_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_value_reg, m_value_next;

    // Combinational controls
    logic                 accept;
    logic                 out_free;
    logic                 ring_we;
    logic [IDX_W-1:0]     ring_waddr;
    logic [WORD_BITS-1:0] ring_wdata;
    logic [IDX_W-1:0]     pos_inc;
    logic [IDX_W:0]       pos_inc_x;
    logic [IDX_W-1:0]     far_addr;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_full;
    logic [WORD_BITS-1:0] sum_word;
    logic [31:0]          draw_val;
    logic [31:0]          result;
    logic [31:0]          seed_ext;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign seed_ext = 32'(s_seed_value);

    // Ring index arithmetic: next position and the lagged index behind it
    assign pos_inc   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
    assign pos_inc_x = {1'b0, pos_inc};
    always_comb begin
        if (pos_inc_x >= BACK_X) begin
            far_addr = IDX_W'(pos_inc_x - BACK_X);
        end else begin
            far_addr = IDX_W'(pos_inc_x + FWD_X);
        end
    end

    // Shared multiplier: fill chain times LAG, or upper half of word times bound
    always_comb begin
        if (state_reg == ST_FILL) begin
            mul_a = 32'(fill_word_reg);
            mul_b = 32'(LAG);
        end else begin
            mul_a = 32'(word_reg[WORD_BITS-1:HALF_BITS]);
            mul_b = bound_reg;
        end
    end
    assign mul_full = {32'b0, mul_a} * {32'b0, mul_b};

    assign sum_word = WORD_BITS'({1'b0, near_rd_reg} + {1'b0, far_rd_reg});
    assign draw_val = prod_reg[HALF_BITS +: 32];

    // Result selection by action
    always_comb begin
        case (action_reg)
            ACT_DRAW:   result = draw_val;
            ACT_COIN:   result = (draw_val > COIN_LIMIT) ? 32'd1 : 32'd0;
            ACT_CHANCE: result = (draw_val < percent_reg) ? 32'd1 : 32'd0;
            ACT_RESEED: result = '0;
            default:    result = '0;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (fill_idx_reg == LAST_IDX) begin
                    state_next = fill_out_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (lfrd_action_t'(s_action) == ACT_RESEED) ? ST_FILL : ST_READ;
                end
            end
            ST_READ: state_next = ST_ADD;
            ST_ADD:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output controls
    always_comb begin
        action_next    = action_reg;
        bound_next     = bound_reg;
        percent_next   = percent_reg;
        pos_next       = pos_reg;
        fill_idx_next  = fill_idx_reg;
        fill_word_next = fill_word_reg;
        fill_out_next  = fill_out_reg;
        word_next      = word_reg;
        prod_next      = prod_reg;
        m_value_next   = m_value_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        ring_we        = 1'b0;
        ring_waddr     = pos_reg;
        ring_wdata     = sum_word;
        case (state_reg)
            ST_FILL: begin
                ring_we        = 1'b1;
                ring_waddr     = fill_idx_reg;
                ring_wdata     = fill_word_reg;
                fill_word_next = mul_full[WORD_BITS-1:0];
                fill_idx_next  = fill_idx_reg + 1'b1;
                if (fill_idx_reg == LAST_IDX) begin
                    pos_next = '0;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    action_next    = lfrd_action_t'(s_action);
                    percent_next   = s_operand;
                    bound_next     = (lfrd_action_t'(s_action) == ACT_DRAW) ? s_operand
                                                                             : CHANCE_BOUND;
                    fill_word_next = seed_ext[WORD_BITS-1:0];
                    fill_idx_next  = '0;
                    fill_out_next  = 1'b1;
                end
            end
            ST_READ: begin
                pos_next = pos_inc;
            end
            ST_ADD: begin
                ring_we    = 1'b1;
                ring_waddr = pos_reg;
                ring_wdata = sum_word;
                word_next  = sum_word;
            end
            ST_MUL: begin
                prod_next = mul_full[PROD_W-1:0];
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = result;
                end
            end
            default: ;
        endcase
    end

    // Ring memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        near_rd_reg <= ring_mem[pos_reg];
        far_rd_reg  <= ring_mem[far_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            pos_reg       <= '0;
            fill_idx_reg  <= '0;
            fill_word_reg <= WORD_BITS'(RESET_SEED);
            fill_out_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fill_idx_reg  <= fill_idx_next;
            fill_word_reg <= fill_word_next;
            fill_out_reg  <= fill_out_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        action_reg  <= action_next;
        bound_reg   <= bound_next;
        percent_reg <= percent_next;
        word_reg    <= word_next;
        prod_reg    <= prod_next;
        m_value_reg <= m_value_next;
    end

    // Ring position never leaves the table
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_IDX)
        else $error("ring position out of range");

    // One word at a time: after an accept the input side is closed
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while busy");

    // A new result appears only from the result state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside result state");

    // The fill pass never runs past the last ring entry
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> (fill_idx_reg <= LAST_IDX))
        else $error("fill index out of range");

endmodule
